// ----- rtl/tdpt_pkg.sv -----
// Package: shared constants and control/status types for the trial division prime tester.
`default_nettype none
package tdpt_pkg;

  localparam int unsigned WIDTH_DEF = 16;
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef struct packed {
    logic load;       // take a new candidate, divisor back to first value
    logic div_init;   // clear remainder, copy candidate into shifter
    logic div_step;   // one restoring remainder step
    logic next_div;   // advance divisor and its square
  } tdpt_cmd_t;

  typedef struct packed {
    logic lt_two;     // candidate below two
    logic sq_gt;      // divisor squared exceeds candidate
    logic rem_zero;   // remainder is zero
  } tdpt_sts_t;

endpackage
`default_nettype wire

// ----- rtl/tdpt_dp.sv -----
// Datapath: candidate, divisor, running square and bit-serial remainder unit.
`default_nettype none
module tdpt_dp #(
  parameter int unsigned WIDTH = tdpt_pkg::WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic [WIDTH-1:0]  candidate,
  input  wire tdpt_pkg::tdpt_cmd_t cmd,
  output tdpt_pkg::tdpt_sts_t    sts
);

  logic [WIDTH-1:0] num_r;
  logic [WIDTH-1:0] div_r;
  logic [WIDTH+1:0] sq_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] shf_r;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] rem_nxt;

  assign trial   = {rem_r, shf_r[WIDTH-1]};
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = (trial >= {1'b0, div_r}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= candidate;
      div_r <= WIDTH'(tdpt_pkg::FIRST_DIVISOR);
      sq_r  <= (WIDTH+2)'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
    end
    if (cmd.next_div) begin
      div_r <= div_r + WIDTH'(1);
      sq_r  <= sq_r + {1'b0, div_r, 1'b1};
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      shf_r <= num_r;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      shf_r <= {shf_r[WIDTH-2:0], 1'b0};
    end
  end

  assign sts.lt_two   = (num_r < WIDTH'(2));
  assign sts.sq_gt    = (sq_r > {2'b00, num_r});
  assign sts.rem_zero = (rem_r == '0);

endmodule
`default_nettype wire

// ----- rtl/tdpt_ctrl.sv -----
// Controller: test sequencer, bit counter and result word register.
`default_nettype none
module tdpt_ctrl #(
  parameter int unsigned WIDTH = tdpt_pkg::WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_is_prime,
  output tdpt_pkg::tdpt_cmd_t      cmd,
  input  wire tdpt_pkg::tdpt_sts_t sts
);

  localparam int unsigned CW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_TEST   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          verdict_r, verdict_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_prime_r, out_prime_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_prime_nxt = out_prime_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.lt_two) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end else if (sts.sq_gt) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = CW'(WIDTH-1);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_TEST;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_TEST: begin
        if (sts.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = verdict_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    verdict_r   <= verdict_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

endmodule
`default_nettype wire

// ----- rtl/trial_division_prime_test_unit.sv -----
// Top level: trial division prime tester, controller plus datapath.
//
//  channel | ports                              | word
//  --------+------------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_candidate   | WIDTH-bit unsigned candidate
//  out     | out_valid, out_stall, out_is_prime | 1 if the candidate is prime
//
// One candidate at a time. A candidate below two goes straight to the result.
// Otherwise each divisor tried takes a square check, a WIDTH-step bit-serial
// remainder and a zero test; the 16-bit worst case is 254 divisors.
// Synchronous active-low reset clears the sequencer and the result valid.
// A new word is taken while a finished result still waits under out_stall.
`default_nettype none
module trial_division_prime_test_unit #(
  parameter int unsigned WIDTH = tdpt_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_candidate,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_is_prime
);

  tdpt_pkg::tdpt_cmd_t cmd;
  tdpt_pkg::tdpt_sts_t sts;

  tdpt_dp #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .candidate (in_candidate),
    .cmd       (cmd),
    .sts       (sts)
  );

  tdpt_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after taking a word");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while test still running");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !sts.sq_gt)
    else $error("remainder step with divisor beyond square root");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire
